// ===== hw/rtl/tbw_pkg.sv =====
// shared widths, item types and weight saturation for the barycentric weight block
package tbw_pkg;

    // fixed point formats
    localparam int COORD_FRAC_BITS  = 4;
    localparam int WEIGHT_FRAC_BITS = 14;

    // field widths
    localparam int CW  = 16;           // coordinate
    localparam int TW  = 16;           // threshold register
    localparam int WW  = 18;           // weight
    localparam int EW  = CW + 1;       // edge difference
    localparam int PW  = 2 * EW;       // product of two differences
    localparam int XW  = PW + 1;       // cross product term
    localparam int AW  = XW + 2;       // numerator of weight a
    localparam int NMW = AW;           // numerator magnitude
    localparam int DMW = XW;           // denominator magnitude
    localparam int DW  = DMW + 1;      // doubled denominator
    localparam int QW  = WW;           // quotient bits kept

    // remainder width of the long division
    localparam int NW  = NMW + WEIGHT_FRAC_BITS + 2;
    localparam int RW  = ((NW > DW + QW) ? NW : DW + QW) + 1;

    // saturation limits and the unit weight
    localparam logic [QW-1:0] W_MAX_MAG = QW'((64'd1 << (WW - 1)) - 64'd1);
    localparam logic [QW-1:0] W_MIN_MAG = QW'(64'd1 << (WW - 1));
    localparam logic [63:0]   ONE64     = 64'd1 << WEIGHT_FRAC_BITS;
    localparam logic          ONE_OVF   = (ONE64 >= (64'd1 << QW));
    localparam logic [QW-1:0] ONE_Q     = ONE64[QW-1:0];

    // classified item handed from front to back
    typedef struct packed {
        logic [NMW-1:0] num_a;
        logic [NMW-1:0] num_b;
        logic [NMW-1:0] num_c;
        logic [DMW-1:0] den;
        logic           neg_a;
        logic           neg_b;
        logic           neg_c;
        logic           degen;
    } tbw_item_t;

    // one weight in the divider
    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QW-1:0] quo;
        logic          ovf;
        logic          neg;
    } tbw_lane_t;

    // one divider stage
    typedef struct packed {
        tbw_lane_t [2:0] lane;
        logic [DW-1:0]   den2;
        logic            degen;
    } tbw_stage_t;

    typedef struct packed {
        logic [WW-1:0] w;
        logic          sat;
    } tbw_weight_t;

    // sign and clamp a quotient magnitude
    function automatic tbw_weight_t sat_weight(input logic [QW-1:0] q, input logic ovf,
                                               input logic neg);
        tbw_weight_t res;
        res.sat = 1'b0;
        res.w   = '0;
        if (!neg) begin
            if (ovf || (q > W_MAX_MAG)) begin
                res.sat = 1'b1;
                res.w   = WW'(W_MAX_MAG);
            end else begin
                res.w   = WW'(q);
            end
        end else begin
            if (ovf || (q > W_MIN_MAG)) begin
                res.sat = 1'b1;
                res.w   = WW'(W_MIN_MAG);
            end else begin
                res.w   = WW'(-q);
            end
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/tbw_front.sv =====
// front part: edge differences, cross product and degenerate check
module tbw_front
    import tbw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [CW-1:0] s_a_x,
    input  logic signed [CW-1:0] s_a_y,
    input  logic signed [CW-1:0] s_b_x,
    input  logic signed [CW-1:0] s_b_y,
    input  logic signed [CW-1:0] s_c_x,
    input  logic signed [CW-1:0] s_c_y,
    input  logic signed [CW-1:0] s_p_x,
    input  logic signed [CW-1:0] s_p_y,
    input  logic [TW-1:0]        thr,
    output logic                 q_valid,
    input  logic                 q_ready,
    output tbw_item_t            q_item
);

    logic [3:0]          vld_reg;
    logic                adv;
    logic signed [EW-1:0] e_reg [3];
    logic signed [EW-1:0] f_reg [3];
    logic signed [PW-1:0] p_reg [6];
    logic signed [XW-1:0] ux_reg, uy_reg, uz_reg;
    tbw_item_t            item_reg;
    tbw_item_t            item_next;
    logic signed [AW-1:0] num_a;
    logic [63:0]          lhs, rhs;

    // stall only when the last stage cannot hand off
    assign adv     = !vld_reg[3] || q_ready;
    assign s_ready = adv;
    assign q_valid = vld_reg[3];
    assign q_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[2:0], s_valid};
        end
    end

    // classify: magnitudes, signs and area test
    always_comb begin
        num_a = AW'(uz_reg) - AW'(ux_reg) - AW'(uy_reg);
        lhs   = 64'(uz_reg[XW-1] ? DMW'(-uz_reg) : DMW'(uz_reg)) << 8;
        rhs   = 64'(thr) << (2 * COORD_FRAC_BITS);
        item_next.num_a = num_a[AW-1] ? NMW'(-num_a) : NMW'(num_a);
        item_next.num_b = uy_reg[XW-1] ? NMW'(-uy_reg) : NMW'(uy_reg);
        item_next.num_c = ux_reg[XW-1] ? NMW'(-ux_reg) : NMW'(ux_reg);
        item_next.den   = uz_reg[XW-1] ? DMW'(-uz_reg) : DMW'(uz_reg);
        item_next.neg_a = num_a[AW-1] ^ uz_reg[XW-1];
        item_next.neg_b = uy_reg[XW-1] ^ uz_reg[XW-1];
        item_next.neg_c = ux_reg[XW-1] ^ uz_reg[XW-1];
        item_next.degen = !(lhs > rhs);
    end

    // datapath stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            e_reg[0] <= EW'(s_c_x) - EW'(s_a_x);
            e_reg[1] <= EW'(s_b_x) - EW'(s_a_x);
            e_reg[2] <= EW'(s_a_x) - EW'(s_p_x);
            f_reg[0] <= EW'(s_c_y) - EW'(s_a_y);
            f_reg[1] <= EW'(s_b_y) - EW'(s_a_y);
            f_reg[2] <= EW'(s_a_y) - EW'(s_p_y);
            p_reg[0] <= PW'(e_reg[1]) * PW'(f_reg[2]);
            p_reg[1] <= PW'(e_reg[2]) * PW'(f_reg[1]);
            p_reg[2] <= PW'(e_reg[2]) * PW'(f_reg[0]);
            p_reg[3] <= PW'(e_reg[0]) * PW'(f_reg[2]);
            p_reg[4] <= PW'(e_reg[0]) * PW'(f_reg[1]);
            p_reg[5] <= PW'(e_reg[1]) * PW'(f_reg[0]);
            ux_reg   <= XW'(p_reg[0]) - XW'(p_reg[1]);
            uy_reg   <= XW'(p_reg[2]) - XW'(p_reg[3]);
            uz_reg   <= XW'(p_reg[4]) - XW'(p_reg[5]);
            item_reg <= item_next;
        end
    end

endmodule

// ===== hw/rtl/tbw_fifo.sv =====
// short item queue between front and back
module tbw_fifo
    import tbw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  tbw_item_t wr_item,
    output logic      rd_valid,
    input  logic      rd_ready,
    output tbw_item_t rd_item
);

    localparam int DEPTH = 4;
    localparam int AB    = $clog2(DEPTH);

    tbw_item_t      mem_reg [DEPTH];
    logic [AB-1:0]  wptr_reg, rptr_reg;
    logic [AB:0]    cnt_reg;
    logic           push, pop;

    assign wr_ready = (cnt_reg != (AB + 1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            if (push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wptr_reg] <= wr_item;
    end

endmodule

// ===== hw/rtl/tbw_back.sv =====
// back part: pipelined rounding division, one quotient bit per stage, then clamp
module tbw_back
    import tbw_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  tbw_item_t     q_item,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [WW-1:0] m_weight_a,
    output logic [WW-1:0] m_weight_b,
    output logic [WW-1:0] m_weight_c,
    output logic          m_degenerate,
    output logic          m_saturated
);

    tbw_stage_t   st_reg  [QW+1];
    tbw_stage_t   st_next [QW+1];
    logic [QW:0]  vld_reg;
    logic         out_vld_reg;
    logic         adv;
    logic [WW-1:0] wa_reg, wb_reg, wc_reg;
    logic         degen_reg, sat_reg;
    tbw_weight_t  wt [3];

    assign adv          = !out_vld_reg || m_ready;
    assign q_ready      = adv;
    assign m_valid      = out_vld_reg;
    assign m_weight_a   = wa_reg;
    assign m_weight_b   = wb_reg;
    assign m_weight_c   = wc_reg;
    assign m_degenerate = degen_reg;
    assign m_saturated  = sat_reg;

    // prep: rounded dividend and overflow test against the quotient range
    always_comb begin
        logic [NMW-1:0] nm [3];
        logic [RW-1:0]  dd;
        nm[0] = q_item.num_a;
        nm[1] = q_item.num_b;
        nm[2] = q_item.num_c;
        dd    = RW'(q_item.den) << 1;
        st_next[0].den2  = DW'(q_item.den) << 1;
        st_next[0].degen = q_item.degen;
        st_next[0].lane[0].neg = q_item.neg_a;
        st_next[0].lane[1].neg = q_item.neg_b;
        st_next[0].lane[2].neg = q_item.neg_c;
        for (int i = 0; i < 3; i++) begin
            st_next[0].lane[i].rem = (RW'(nm[i]) << (WEIGHT_FRAC_BITS + 1))
                                     + RW'(q_item.den);
            st_next[0].lane[i].quo = '0;
            st_next[0].lane[i].ovf = (st_next[0].lane[i].rem >= (dd << QW));
        end
    end

    // restoring division stages
    for (genvar s = 1; s <= QW; s++) begin : g_div
        always_comb begin
            logic [RW-1:0] t;
            t = RW'(st_reg[s-1].den2) << (QW - s);
            st_next[s] = st_reg[s-1];
            for (int i = 0; i < 3; i++) begin
                if (st_reg[s-1].lane[i].rem >= t) begin
                    st_next[s].lane[i].rem          = st_reg[s-1].lane[i].rem - t;
                    st_next[s].lane[i].quo[QW - s]  = 1'b1;
                end
            end
        end
    end

    // final sign and clamp
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (st_reg[QW].degen) begin
                wt[i] = sat_weight(ONE_Q, ONE_OVF, (i == 0));
            end else begin
                wt[i] = sat_weight(st_reg[QW].lane[i].quo, st_reg[QW].lane[i].ovf,
                                   st_reg[QW].lane[i].neg);
            end
        end
    end

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[QW-1:0], q_valid};
            out_vld_reg <= vld_reg[QW];
        end
    end

    // stage payload and output register
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int s = 0; s <= QW; s++) begin
                st_reg[s] <= st_next[s];
            end
            wa_reg    <= wt[0].w;
            wb_reg    <= wt[1].w;
            wc_reg    <= wt[2].w;
            degen_reg <= st_reg[QW].degen;
            sat_reg   <= wt[0].sat || wt[1].sat || wt[2].sat;
        end
    end

endmodule

// ===== hw/rtl/triangle_barycentric_weights.sv =====
// top level of the barycentric weight block
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  s_       | s_valid / s_ready    | a_x a_y b_x b_y c_x c_y p_x p_y
//  m_       | m_valid / m_ready    | weight_a weight_b weight_c degenerate saturated
//  cfg_     | cfg_valid / cfg_ready| area_threshold
//
// one item per cycle sustained while m_ready is high; an item passes the registered
// front, the queue, then 1 + 18 divider stages (one quotient bit each) and the
// output register. reset is synchronous active low and sets area_threshold to 2.
// the front stalls only when the 4-entry queue is full; the back stalls
// only when a result waits in the output register and m_ready is low.
module triangle_barycentric_weights
    import tbw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [CW-1:0] s_a_x,
    input  logic signed [CW-1:0] s_a_y,
    input  logic signed [CW-1:0] s_b_x,
    input  logic signed [CW-1:0] s_b_y,
    input  logic signed [CW-1:0] s_c_x,
    input  logic signed [CW-1:0] s_c_y,
    input  logic signed [CW-1:0] s_p_x,
    input  logic signed [CW-1:0] s_p_y,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [WW-1:0] m_weight_a,
    output logic signed [WW-1:0] m_weight_b,
    output logic signed [WW-1:0] m_weight_c,
    output logic                 m_degenerate,
    output logic                 m_saturated,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TW-1:0]        cfg_data
);

    logic [TW-1:0] thr_reg;
    logic          fq_valid, fq_ready, bq_valid, bq_ready;
    tbw_item_t     fq_item, bq_item;

    // threshold register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= TW'(2);
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    tbw_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_a_x   (s_a_x),
        .s_a_y   (s_a_y),
        .s_b_x   (s_b_x),
        .s_b_y   (s_b_y),
        .s_c_x   (s_c_x),
        .s_c_y   (s_c_y),
        .s_p_x   (s_p_x),
        .s_p_y   (s_p_y),
        .thr     (thr_reg),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_item  (fq_item)
    );

    tbw_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_item  (fq_item),
        .rd_valid (bq_valid),
        .rd_ready (bq_ready),
        .rd_item  (bq_item)
    );

    tbw_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (bq_valid),
        .q_ready      (bq_ready),
        .q_item       (bq_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_weight_a   (m_weight_a),
        .m_weight_b   (m_weight_b),
        .m_weight_c   (m_weight_c),
        .m_degenerate (m_degenerate),
        .m_saturated  (m_saturated)
    );

endmodule

// ===== verif/tb_triangle_barycentric_weights.sv =====
// testbench for the barycentric weight block: random and directed triangles checked against a predictor
module tb_triangle_barycentric_weights;
    import tbw_pkg::*;

    typedef struct {
        logic signed [CW-1:0] ax, ay, bx, by, cx, cy, px, py;
    } tri_item_t;

    typedef struct {
        logic signed [WW-1:0] wa, wb, wc;
        logic                 degen, sat;
    } weights_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0, m_ready = 1'b0, cfg_valid = 1'b0;
    logic s_ready, m_valid, cfg_ready;
    logic signed [CW-1:0] s_a_x = '0, s_a_y = '0, s_b_x = '0, s_b_y = '0;
    logic signed [CW-1:0] s_c_x = '0, s_c_y = '0, s_p_x = '0, s_p_y = '0;
    logic signed [WW-1:0] m_weight_a, m_weight_b, m_weight_c;
    logic m_degenerate, m_saturated;
    logic [TW-1:0] cfg_data = '0;

    triangle_barycentric_weights DUT (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    tri_item_t pending_tris[$];
    weights_t  expected_weights[$];
    logic [TW-1:0] threshold = 16'd2;
    int errors = 0;
    int checked = 0;
    int degen_seen = 0;
    int sat_seen = 0;
    longint cycles = 0;
    bit quiet = 1'b0;     // no idling in the last part
    int s_gap = 0, m_gap = 0;

    // rounded, saturated weight: round(num*2^14/den), ties away from zero
    function automatic logic signed [WW-1:0] weight_of(longint num, longint den, ref bit sat);
        longint n, d, q;
        bit neg;
        n = (num < 0 ? -num : num) <<< WEIGHT_FRAC_BITS;
        d = den < 0 ? -den : den;
        q = (2 * n + d) / (2 * d);
        neg = (num < 0) != (den < 0);
        if (neg) q = -q;
        if (q > 131071) begin sat = 1; q = 131071; end
        if (q < -131072) begin sat = 1; q = -131072; end
        return q[WW-1:0];
    endfunction

    function automatic weights_t predict_weights(tri_item_t t, logic [TW-1:0] thr);
        weights_t r;
        longint e0, e1, e2, f0, f1, f2, ux, uy, uz, mag;
        bit sat;
        e0 = longint'(t.cx) - t.ax; e1 = longint'(t.bx) - t.ax; e2 = longint'(t.ax) - t.px;
        f0 = longint'(t.cy) - t.ay; f1 = longint'(t.by) - t.ay; f2 = longint'(t.ay) - t.py;
        ux = e1 * f2 - e2 * f1;
        uy = e2 * f0 - e0 * f2;
        uz = e0 * f1 - e1 * f0;
        mag = uz < 0 ? -uz : uz;
        sat = 0;
        r.degen = !((mag <<< 8) > (longint'(thr) <<< (2 * COORD_FRAC_BITS)));
        if (r.degen) begin
            r.wa = -(18'sd1 <<< WEIGHT_FRAC_BITS);
            r.wb = 18'sd1 <<< WEIGHT_FRAC_BITS;
            r.wc = 18'sd1 <<< WEIGHT_FRAC_BITS;
        end else begin
            r.wa = weight_of(uz - ux - uy, uz, sat);
            r.wb = weight_of(uy, uz, sat);
            r.wc = weight_of(ux, uz, sat);
        end
        r.sat = sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_weights.push_back(predict_weights(pending_tris.pop_front(), threshold));
            end
            if (!(s_valid && !s_ready)) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_tris.size() > (s_valid && s_ready ? 0 : 0) &&
                             !(s_valid && s_ready && pending_tris.size() == 0)) begin
                    if (pending_tris.size() != 0) begin
                        s_valid <= 1'b1;
                        s_a_x <= pending_tris[0].ax; s_a_y <= pending_tris[0].ay;
                        s_b_x <= pending_tris[0].bx; s_b_y <= pending_tris[0].by;
                        s_c_x <= pending_tris[0].cx; s_c_y <= pending_tris[0].cy;
                        s_p_x <= pending_tris[0].px; s_p_y <= pending_tris[0].py;
                        if (!quiet && $urandom_range(0, 9) == 0) s_gap <= $urandom_range(1, 8);
                    end else begin
                        s_valid <= 1'b0;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and ready pattern
    always @(posedge aclk) begin
        cycles++;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_weights.size() == 0) begin
                    report_mismatch("unexpected item", 64'sd1, 64'sd0);
                end else begin
                    weights_t w;
                    w = expected_weights.pop_front();
                    checked++;
                    degen_seen += int'(w.degen);
                    sat_seen += int'(w.sat);
                    if (m_weight_a !== w.wa)
                        report_mismatch("weight_a", longint'(m_weight_a), longint'(w.wa));
                    if (m_weight_b !== w.wb)
                        report_mismatch("weight_b", longint'(m_weight_b), longint'(w.wb));
                    if (m_weight_c !== w.wc)
                        report_mismatch("weight_c", longint'(m_weight_c), longint'(w.wc));
                    if (m_degenerate !== w.degen)
                        report_mismatch("degenerate", longint'(m_degenerate),
                                        longint'(w.degen));
                    if (m_saturated !== w.sat)
                        report_mismatch("saturated", longint'(m_saturated), longint'(w.sat));
                end
            end
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0) m_gap <= $urandom_range(1, 8);
            end
        end
        if (cycles > 400000) begin
            $display("timeout with %0d items outstanding", expected_weights.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic tri_item_t rand_tri(int spread);
        tri_item_t t;
        logic signed [CW-1:0] base_x, base_y;
        base_x = CW'($urandom);
        base_y = CW'($urandom);
        if (spread == 0) begin
            // full-range corners
            t.ax = CW'($urandom); t.ay = CW'($urandom);
            t.bx = CW'($urandom); t.by = CW'($urandom);
            t.cx = CW'($urandom); t.cy = CW'($urandom);
            t.px = CW'($urandom); t.py = CW'($urandom);
        end else begin
            // local triangle with point nearby
            t.ax = CW'(base_x + $signed($urandom_range(0, 2 * spread)) - spread);
            t.ay = CW'(base_y + $signed($urandom_range(0, 2 * spread)) - spread);
            t.bx = CW'(base_x + $signed($urandom_range(0, 2 * spread)) - spread);
            t.by = CW'(base_y + $signed($urandom_range(0, 2 * spread)) - spread);
            t.cx = CW'(base_x + $signed($urandom_range(0, 2 * spread)) - spread);
            t.cy = CW'(base_y + $signed($urandom_range(0, 2 * spread)) - spread);
            t.px = CW'(base_x + $signed($urandom_range(0, 4 * spread)) - 2 * spread);
            t.py = CW'(base_y + $signed($urandom_range(0, 4 * spread)) - 2 * spread);
        end
        return t;
    endfunction

    task automatic add_tri(int ax, int ay, int bx, int by, int cx, int cy, int px, int py);
        tri_item_t t;
        t.ax = CW'(ax); t.ay = CW'(ay); t.bx = CW'(bx); t.by = CW'(by);
        t.cx = CW'(cx); t.cy = CW'(cy); t.px = CW'(px); t.py = CW'(py);
        pending_tris.push_back(t);
    endtask

    task automatic wait_drained();
        while (pending_tris.size() != 0 || s_valid || expected_weights.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [TW-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        threshold = v;
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial begin
        logic [TW-1:0] thr_list[5];
        int spreads[4];
        thr_list = '{16'd0, 16'd65535, 16'd1, 16'd300, 16'd2};
        spreads = '{0, 8, 64, 2000};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset threshold, extremes, degenerate, zero area, saturation
        add_tri(0, 0, 16, 0, 0, 16, 4, 4);
        add_tri(0, 0, 16, 0, 0, 16, 8, 8);
        add_tri(0, 0, 16, 0, 0, 16, 0, 0);
        add_tri(0, 0, 1, 0, 0, 1, 0, 0);
        add_tri(0, 0, 2, 0, 0, 1, 1, 0);
        add_tri(5, 5, 5, 5, 5, 5, 5, 5);
        add_tri(0, 0, 16, 16, 32, 32, 7, 9);
        add_tri(0, 0, 1, 0, 0, 1, 32767, -32768);
        add_tri(0, 0, 1, 0, 0, 1, -32768, 32767);
        add_tri(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0);
        add_tri(32767, 32767, -32768, 32767, 32767, -32768, -32768, -32768);
        add_tri(-32768, 32767, 32767, -32768, 32767, 32767, -1, -1);
        add_tri(0, 0, 3, 0, 0, 3, 1, 1);
        add_tri(0, 0, -3, 0, 0, 3, -1, 1);
        add_tri(0, 0, 2, 1, 1, 2, 100, -50);
        add_tri(0, 0, 3, 0, 0, 1, 1, 0);
        wait_drained();

        // random phases over threshold settings, the extremes among them
        foreach (thr_list[k]) begin
            write_threshold(thr_list[k]);
            if (k == 4) quiet = 1'b1;
            repeat (k == 4 ? 150 : 170)
                pending_tris.push_back(rand_tri(spreads[$urandom_range(0, 3)]));
            wait_drained();
        end

        $display("checked %0d items over %0d threshold settings", checked, 6);
        $display("degenerate results %0d, saturated results %0d", degen_seen, sat_seen);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
